// ===== design/hai_pkg.sv =====
package hai_pkg;

  // field widths
  localparam int IDX_W  = 8;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 31;
  // heading width with headroom for the 2*pi lift and the quotient add
  localparam int EXT_W  = 34;

  // angle constants in q3.28 radians
  localparam logic signed [EXT_W-1:0] HEAD_PI     = 34'sd843314857;
  localparam logic signed [EXT_W-1:0] HEAD_PI_2   = 34'sd421657428;
  localparam logic signed [EXT_W-1:0] HEAD_TWO_PI = 34'sd1686629713;

  // input item kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_LAUNCH,
    ST_DIVW,
    ST_WRAP,
    ST_RESP
  } hai_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_ALIGN,
    MD_DIV
  } hai_md_state_t;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic              start;
    logic [HEAD_W-1:0] mag;  // |h1 - h0|
    logic [POS_W-1:0]  ds;   // q - p0, positive
    logic [POS_W-1:0]  dp;   // p1 - p0, larger than ds
  } hai_md_req_t;

endpackage

// ===== design/heading_angle_interpolation.sv =====
// load item: taken while idle, written straight into the tables, no result
// query item: scans the table one entry per cycle from entry 0 up to last_index
//   or to the first segment that holds the query; such a segment goes on to the
//   shared shift-add multiplier / restoring divider
// one query at a time; in_tready is high only while idle
// reset (rst_n low at a clock edge) clears control state and last_index; tables stay undefined
module heading_angle_interpolation #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] entry_index, [39:8] breakpoint_position, [70:40] heading_value,
  // [102:71] query_position, [103] zero
  input  logic [103:0] in_tdata,
  // [0] action
  input  logic         in_tuser,
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // [30:0] heading_out, [31] zero
  output logic [31:0]  out_tdata,
  // [0] found
  output logic         out_tuser,
  // last_index register
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = hai_pkg::EXT_W;

  // unpack the input item
  logic [7:0]                       in_entry_index;
  logic signed [hai_pkg::POS_W-1:0] in_breakpoint_position;
  logic [hai_pkg::HEAD_W-1:0]       in_heading_value;
  logic signed [hai_pkg::POS_W-1:0] in_query_position;
  logic                             in_action;

  assign in_entry_index         = in_tdata[7:0];
  assign in_breakpoint_position = $signed(in_tdata[39:8]);
  assign in_heading_value       = in_tdata[70:40];
  assign in_query_position      = $signed(in_tdata[102:71]);
  assign in_action              = in_tuser;

  hai_pkg::hai_state_t state_r, state_nxt;

  logic [7:0]  last_index_r;
  logic        out_vld_r, out_vld_nxt;
  logic [30:0] out_heading_r, out_heading_nxt;
  logic        out_found_r, out_found_nxt;

  // scan control
  logic [AW-1:0] last_r, last_nxt;
  logic [AW-1:0] ctr_r, ctr_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          issue_done_r, issue_done_nxt;
  logic          vld_r, vld_nxt;

  // query and running result
  logic signed [31:0]   s_r, s_nxt;
  logic                 found_r, found_nxt;
  logic [30:0]          val_r, val_nxt;
  logic signed [31:0]   prev_p_r, prev_p_nxt;
  logic signed [EW-1:0] prev_h_r, prev_h_nxt;

  // segment under interpolation
  logic signed [31:0]   p0_r, p0_nxt, p1_r, p1_nxt;
  logic signed [EW-1:0] h0_r, h0_nxt, h1_r, h1_nxt;
  logic                 wrap_r, wrap_nxt;
  logic                 dh_neg_r, dh_neg_nxt;
  logic signed [EW-1:0] r_r, r_nxt;

  // table ports
  logic                       accept;
  logic                       load_we;
  logic [AW-1:0]              rd_addr;
  logic [31:0]                ram_p_rdata;
  logic [hai_pkg::HEAD_W-1:0] ram_h_rdata;
  logic signed [31:0]         cur_p;
  logic signed [EW-1:0]       cur_h;

  // shared multiply/divide unit
  hai_pkg::hai_md_req_t       md_req;
  logic                       md_done;
  logic [hai_pkg::HEAD_W-1:0] md_quot;

  // scan compares
  logic has_prev, gt_prev, lt_cur, eq_prev, eq_cur, at_last, seg_hit;

  // segment preparation
  logic                 big0, big1, opp, wrap_c;
  logic signed [EW-1:0] dh_a, dh_b;
  logic signed [32:0]   ds_full, dp_full;

  assign in_tready = (state_r == hai_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  // slots beyond the table depth are dropped
  assign load_we   = accept && (in_action == hai_pkg::ACT_LOAD) &&
                     (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign rd_addr   = ctr_r;

  hai_ram #(
    .WIDTH (hai_pkg::POS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_breakpoint_position),
    .raddr (rd_addr),
    .rdata (ram_p_rdata)
  );

  hai_ram #(
    .WIDTH (hai_pkg::HEAD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_head_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_heading_value),
    .raddr (rd_addr),
    .rdata (ram_h_rdata)
  );

  hai_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .quot  (md_quot)
  );

  assign cur_p = $signed(ram_p_rdata);
  assign cur_h = {{(EW - hai_pkg::HEAD_W){ram_h_rdata[hai_pkg::HEAD_W-1]}}, ram_h_rdata};

  // entry k arrives with entry k-1 held in prev: decide entry k-1 now,
  // and entry k as well once k is the last one
  assign has_prev = (k_r != '0);
  assign gt_prev  = (s_r > prev_p_r);
  assign lt_cur   = (s_r < cur_p);
  assign eq_prev  = (s_r == prev_p_r);
  assign eq_cur   = (s_r == cur_p);
  assign at_last  = (k_r == last_r);
  assign seg_hit  = has_prev && gt_prev && lt_cur;

  // angle wrap test: both ends beyond pi/2 with opposite signs
  assign big0   = (h0_r > hai_pkg::HEAD_PI_2) || (h0_r < -hai_pkg::HEAD_PI_2);
  assign big1   = (h1_r > hai_pkg::HEAD_PI_2) || (h1_r < -hai_pkg::HEAD_PI_2);
  assign opp    = ((h0_r < 0) && (h1_r > 0)) || ((h0_r > 0) && (h1_r < 0));
  assign wrap_c = big0 && big1 && opp;

  assign dh_a    = h1_r - h0_r;
  assign dh_b    = h0_r - h1_r;
  assign ds_full = {s_r[31], s_r} - {p0_r[31], p0_r};
  assign dp_full = {p1_r[31], p1_r} - {p0_r[31], p0_r};

  always_comb begin
    state_nxt       = state_r;
    out_vld_nxt     = out_vld_r && !out_tready;
    out_heading_nxt = out_heading_r;
    out_found_nxt   = out_found_r;
    last_nxt        = last_r;
    ctr_nxt         = ctr_r;
    k_nxt           = k_r;
    issue_done_nxt  = issue_done_r;
    vld_nxt         = 1'b0;
    s_nxt           = s_r;
    found_nxt       = found_r;
    val_nxt         = val_r;
    prev_p_nxt      = prev_p_r;
    prev_h_nxt      = prev_h_r;
    p0_nxt          = p0_r;
    p1_nxt          = p1_r;
    h0_nxt          = h0_r;
    h1_nxt          = h1_r;
    wrap_nxt        = wrap_r;
    dh_neg_nxt      = dh_neg_r;
    r_nxt           = r_r;
    md_req          = '0;

    unique case (state_r)
      hai_pkg::ST_IDLE: begin
        if (accept && (in_action == hai_pkg::ACT_QUERY)) begin
          s_nxt          = in_query_position;
          // scan bound clamped to the table depth
          last_nxt       = (32'(last_index_r) > 32'(TABLE_DEPTH - 1)) ?
                           AW'(TABLE_DEPTH - 1) : AW'(last_index_r);
          ctr_nxt        = '0;
          issue_done_nxt = 1'b0;
          found_nxt      = 1'b0;
          val_nxt        = '0;
          state_nxt      = hai_pkg::ST_SCAN;
        end
      end

      hai_pkg::ST_SCAN: begin
        // read one entry per cycle, evaluate it in the next cycle
        if (!issue_done_r) begin
          vld_nxt = 1'b1;
          k_nxt   = ctr_r;
          if (ctr_r == last_r) begin
            issue_done_nxt = 1'b1;
          end else begin
            ctr_nxt = ctr_r + 1'b1;
          end
        end
        if (vld_r) begin
          prev_p_nxt = cur_p;
          prev_h_nxt = cur_h;
          if (seg_hit) begin
            p0_nxt    = prev_p_r;
            p1_nxt    = cur_p;
            h0_nxt    = prev_h_r;
            h1_nxt    = cur_h;
            state_nxt = hai_pkg::ST_PREP;
          end else begin
            // exact matches keep the later entry
            if (has_prev && eq_prev) begin
              found_nxt = 1'b1;
              val_nxt   = prev_h_r[30:0];
            end
            if (at_last) begin
              if (eq_cur) begin
                found_nxt = 1'b1;
                val_nxt   = cur_h[30:0];
              end
              state_nxt = hai_pkg::ST_RESP;
            end
          end
        end
      end

      hai_pkg::ST_PREP: begin
        // lift the negative end by 2*pi across the +-pi seam
        wrap_nxt = wrap_c;
        if (wrap_c) begin
          if (h0_r < 0) begin
            h0_nxt = h0_r + hai_pkg::HEAD_TWO_PI;
          end else begin
            h1_nxt = h1_r + hai_pkg::HEAD_TWO_PI;
          end
        end
        state_nxt = hai_pkg::ST_LAUNCH;
      end

      hai_pkg::ST_LAUNCH: begin
        dh_neg_nxt   = (h1_r < h0_r);
        md_req.start = 1'b1;
        md_req.mag   = (h1_r < h0_r) ? dh_b[30:0] : dh_a[30:0];
        md_req.ds    = ds_full[31:0];
        md_req.dp    = dp_full[31:0];
        state_nxt    = hai_pkg::ST_DIVW;
      end

      hai_pkg::ST_DIVW: begin
        if (md_done) begin
          r_nxt     = dh_neg_r ? (h0_r - {3'b000, md_quot}) : (h0_r + {3'b000, md_quot});
          state_nxt = hai_pkg::ST_WRAP;
        end
      end

      hai_pkg::ST_WRAP: begin
        found_nxt = 1'b1;
        val_nxt   = r_r[30:0];
        if (wrap_r) begin
          if (r_r > hai_pkg::HEAD_PI) begin
            val_nxt = 31'(r_r - hai_pkg::HEAD_TWO_PI);
          end else if (r_r < -hai_pkg::HEAD_PI) begin
            val_nxt = 31'(r_r + hai_pkg::HEAD_TWO_PI);
          end
        end
        state_nxt = hai_pkg::ST_RESP;
      end

      hai_pkg::ST_RESP: begin
        // wait for room in the output register
        if (!out_vld_r || out_tready) begin
          out_vld_nxt     = 1'b1;
          out_found_nxt   = found_r;
          out_heading_nxt = found_r ? val_r : 31'd0;
          state_nxt       = hai_pkg::ST_IDLE;
        end
      end

      default: state_nxt = hai_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hai_pkg::ST_IDLE;
      out_vld_r    <= 1'b0;
      last_index_r <= '0;
      vld_r        <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_vld_r    <= out_vld_nxt;
      vld_r        <= vld_nxt;
      issue_done_r <= issue_done_nxt;
      if (cfg_wr_en) begin
        last_index_r <= cfg_wr_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    out_heading_r <= out_heading_nxt;
    out_found_r   <= out_found_nxt;
    last_r        <= last_nxt;
    ctr_r         <= ctr_nxt;
    k_r           <= k_nxt;
    s_r           <= s_nxt;
    found_r       <= found_nxt;
    val_r         <= val_nxt;
    prev_p_r      <= prev_p_nxt;
    prev_h_r      <= prev_h_nxt;
    p0_r          <= p0_nxt;
    p1_r          <= p1_nxt;
    h0_r          <= h0_nxt;
    h1_r          <= h1_nxt;
    wrap_r        <= wrap_nxt;
    dh_neg_r      <= dh_neg_nxt;
    r_r           <= r_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_heading_r};
  assign out_tuser  = out_found_r;

endmodule

// ===== design/hai_ram.sv =====
module hai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hai_muldiv.sv =====
module hai_muldiv (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hai_pkg::hai_md_req_t                 req,
  output logic                                 done,
  output logic [hai_pkg::HEAD_W-1:0]           quot
);

  hai_pkg::hai_md_state_t state_r, state_nxt;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [31:0]                  hi_r, hi_nxt;
  logic [31:0]                  lo_r, lo_nxt;
  logic [hai_pkg::HEAD_W-1:0]   a_r, a_nxt;
  logic [31:0]                  d_r, d_nxt;

  // one adder shared by the multiply and divide steps
  logic [33:0] add_x, add_y, add_sum;
  logic        add_c;
  logic        ge;

  assign add_sum = add_x + add_y + {33'd0, add_c};
  assign ge      = ~add_sum[33];

  always_comb begin
    add_x = '0;
    add_y = '0;
    add_c = 1'b0;
    if (state_r == hai_pkg::MD_DIV) begin
      add_x = {1'b0, hi_r, lo_r[31]};
      add_y = ~{2'b00, d_r};
      add_c = 1'b1;
    end else begin
      add_x = {2'b00, hi_r};
      add_y = lo_r[0] ? {3'b000, a_r} : 34'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    unique case (state_r)
      hai_pkg::MD_IDLE: begin
        if (req.start) begin
          a_nxt     = req.mag;
          d_nxt     = req.dp;
          hi_nxt    = '0;
          lo_nxt    = req.ds;
          cnt_nxt   = '0;
          state_nxt = hai_pkg::MD_MUL;
        end
      end
      hai_pkg::MD_MUL: begin
        // shift-add, product ends in {hi, lo}
        hi_nxt  = add_sum[32:1];
        lo_nxt  = {add_sum[0], lo_r[31:1]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          state_nxt = hai_pkg::MD_ALIGN;
        end
      end
      hai_pkg::MD_ALIGN: begin
        // quotient fits 31 bits, so the partial remainder starts at bit 31
        hi_nxt    = {hi_r[30:0], lo_r[31]};
        lo_nxt    = {lo_r[30:0], 1'b0};
        cnt_nxt   = '0;
        state_nxt = hai_pkg::MD_DIV;
      end
      hai_pkg::MD_DIV: begin
        // restoring step, one quotient bit per cycle
        hi_nxt  = ge ? add_sum[31:0] : {hi_r[30:0], lo_r[31]};
        lo_nxt  = {lo_r[30:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd30) begin
          done_nxt  = 1'b1;
          state_nxt = hai_pkg::MD_IDLE;
        end
      end
      default: state_nxt = hai_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hai_pkg::MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    a_r   <= a_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = lo_r[hai_pkg::HEAD_W-1:0];

endmodule

// ===== dv/heading_angle_interpolation_tb.sv =====
module heading_angle_interpolation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W  = hai_pkg::IDX_W;
  localparam int POS_W  = hai_pkg::POS_W;
  localparam int HEAD_W = hai_pkg::HEAD_W;

  localparam int CLK_PERIOD    = 8;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDLE_PCT      = 37;    // chance per cycle that a side idles
  localparam int TOTAL_ITEMS   = 1320;  // directed plus random items
  localparam int SETTLE_CYCLES = 8;     // quiet time before a register write
  localparam int TAIL_CYCLES   = 400;   // longer than the slowest query
  localparam int STALL_LIMIT   = 6000;  // cycles without any handshake

  // q3.28 angle constants widened for the predictor arithmetic
  localparam longint PI_Q     = hai_pkg::HEAD_PI;
  localparam longint HALF_PI  = hai_pkg::HEAD_PI_2;
  localparam longint TWO_PI_Q = hai_pkg::HEAD_TWO_PI;

  // one result item: heading in q3.28 and the found flag
  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              found;
  } heading_result_t;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  // [7:0] entry_index, [39:8] breakpoint_position, [70:40] heading_value,
  // [102:71] query_position, [103] zero
  logic [103:0] in_tdata    = '0;
  // [0] action
  logic         in_tuser    = 1'b0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  // [30:0] heading_out, [31] zero
  logic [31:0]  out_tdata;
  // [0] found
  logic         out_tuser;
  logic         cfg_wr_en   = 1'b0;
  logic [7:0]   cfg_wr_data = '0;

  // shadow copy of the path table and the scan bound
  logic signed [POS_W-1:0]  pos_tbl  [TABLE_ENTRIES];
  logic signed [HEAD_W-1:0] head_tbl [TABLE_ENTRIES];
  logic [IDX_W-1:0]         scan_last = '0;

  // headings still owed by the block, oldest first
  heading_result_t heading_expect_q [$];

  bit no_idle       = 1'b0;  // both sides run flat out while set
  int item_count    = 0;
  int load_count    = 0;
  int query_count   = 0;
  int setting_count = 0;
  int found_count   = 0;
  int outside_count = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  heading_angle_interpolation dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // heading predictor
  // ---------------------------------------------------------------------------

  // scan entries 0..scan_last; an exact hit keeps scanning so a later equal
  // position wins, a segment that strictly holds the query ends the scan
  function automatic heading_result_t predict_heading(logic signed [POS_W-1:0] qpos);
    heading_result_t res;
    longint      s, p0, p1, h0, h1, dh, r;
    logic [63:0] mag_u, ds_u, dp_u, quo;
    bit          wrap, done;
    int          i, top;
    res  = '0;
    done = 1'b0;
    s    = qpos;
    top  = int'(scan_last);
    for (i = 0; i <= top && !done; i++) begin
      p0 = pos_tbl[i];
      if (s > p0) begin
        if (i == top) begin
          // beyond the last entry: stop, found only if an earlier entry matched exactly
          done = 1'b1;
        end else if (s < pos_tbl[i+1]) begin
          p1 = pos_tbl[i+1];
          h0 = head_tbl[i];
          h1 = head_tbl[i+1];
          // both ends past pi/2 on opposite sides: go the short way round
          wrap = ((h0 < 0 ? -h0 : h0) > HALF_PI) && ((h1 < 0 ? -h1 : h1) > HALF_PI) &&
                 ((h0 < 0) != (h1 < 0));
          if (wrap) begin
            if (h0 < 0) h0 += TWO_PI_Q;
            else h1 += TWO_PI_Q;
          end
          dh    = h1 - h0;
          mag_u = (dh < 0) ? -dh : dh;
          ds_u  = s - p0;
          dp_u  = p1 - p0;
          // product fits 64 bits, quotient truncates
          quo   = (mag_u * ds_u) / dp_u;
          r     = (dh < 0) ? h0 - longint'(quo) : h0 + longint'(quo);
          if (wrap) begin
            if (r > PI_Q) r -= TWO_PI_Q;
            else if (r < -PI_Q) r += TWO_PI_Q;
          end
          res.heading = HEAD_W'(r);
          res.found   = 1'b1;
          done        = 1'b1;
        end
      end else if (s == p0) begin
        res.heading = head_tbl[i];
        res.found   = 1'b1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // heading within [-pi, pi], biased toward the wrap band past pi/2
  function automatic logic signed [HEAD_W-1:0] rand_heading();
    int unsigned pick;
    longint      mag;
    pick = $urandom_range(9);
    if (pick == 0) mag = PI_Q;
    else if (pick < 5) mag = HALF_PI + 1 + longint'($urandom_range(32'(PI_Q - HALF_PI - 1)));
    else mag = longint'($urandom_range(32'(PI_Q)));
    return HEAD_W'(($urandom_range(1) != 0) ? -mag : mag);
  endfunction

  // query position: mostly inside a segment or on an entry, some just off
  // the ends of the table, some anywhere
  function automatic logic signed [POS_W-1:0] pick_query(int top);
    int unsigned kind;
    int          seg;
    longint      lo, hi;
    kind = $urandom_range(99);
    seg  = int'($urandom_range(32'(top)));
    lo   = pos_tbl[seg];
    if (kind < 50 && seg < top) begin
      hi = pos_tbl[seg+1];
      if (hi - lo > 1) return POS_W'(lo + 1 + longint'($urandom_range(32'(hi - lo - 2))));
    end
    if (kind < 80) return POS_W'(lo);
    if (kind < 90) begin
      if ($urandom_range(1) != 0) return POS_W'(longint'(pos_tbl[0]) - 1);
      return POS_W'(longint'(pos_tbl[top]) + 1);
    end
    return POS_W'($urandom());
  endfunction

  // present one item at the falling edge, hold it until taken, then update
  // the shadow table or queue the predicted heading
  task automatic send_item(logic act, logic [IDX_W-1:0] idx, logic signed [POS_W-1:0] pos,
                           logic signed [HEAD_W-1:0] head, logic signed [POS_W-1:0] qpos);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {1'b0, qpos, head, pos, idx};
    do @(posedge clk); while (!in_tready);
    if (act == hai_pkg::ACT_LOAD) begin
      pos_tbl[idx]  = pos;
      head_tbl[idx] = head;
      load_count++;
    end else begin
      heading_expect_q.push_back(predict_heading(qpos));
      query_count++;
    end
    item_count++;
    @(negedge clk);
  endtask

  // wait until every owed heading has come back and the block is at rest
  task automatic drain_block();
    in_tvalid = 1'b0;
    while (heading_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_last_index(logic [IDX_W-1:0] value);
    drain_block();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    scan_last   = value;
    setting_count++;
  endtask

  task automatic send_load(logic [IDX_W-1:0] idx, logic signed [POS_W-1:0] pos,
                           logic signed [HEAD_W-1:0] head);
    send_item(hai_pkg::ACT_LOAD, idx, pos, head, POS_W'($urandom()));
  endtask

  task automatic send_query(logic signed [POS_W-1:0] qpos);
    send_item(hai_pkg::ACT_QUERY, IDX_W'($urandom()), POS_W'($urandom()), rand_heading(),
              qpos);
  endtask

  // fill entries 0..top with ascending positions, either spread over the
  // whole q16.16 range or packed close together; a few repeat the previous
  // position so equal entries show up
  task automatic load_random_table(int top);
    longint span, base, p;
    int     i;
    if ($urandom_range(1) != 0) begin
      span = (longint'(1) << 32) / longint'(top + 1);
      base = -(longint'(1) << 31);
    end else begin
      span = longint'(1) << $urandom_range(16, 1);
      base = -(longint'(1) << 31) +
             longint'($urandom_range(32'((longint'(1) << 32) - 1 - longint'(top + 1) * span)));
    end
    for (i = 0; i <= top; i++) begin
      p = base + longint'(i) * span + longint'($urandom_range(32'(span - 1)));
      if (i > 0 && $urandom_range(19) == 0) p = pos_tbl[i-1];
      send_load(IDX_W'(i), POS_W'(p), rand_heading());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // table spanning the full position range with headings at +-pi;
  // exact hits on the first and last entry, plain segments, and queries
  // that fall outside once the scan bound is pulled in
  task automatic test_table_extremes();
    write_last_index(8'd4);
    send_load(8'd0, 32'sh8000_0000, -31'sd800000000);
    send_load(8'd1, -32'sd65536, 31'sd843314857);
    send_load(8'd2, 32'sd0, 31'sd600000000);
    send_load(8'd3, 32'sd131072, -31'sd700000000);
    send_load(8'd4, 32'sh7FFF_FFFF, -31'sd843314857);
    send_query(32'sh8000_0000);
    send_query(32'sh7FFF_FFFF);
    send_query(32'sd1000000);
    send_query(-32'sd1);
    write_last_index(8'd3);
    send_query(32'sh7FFF_FFFF);
    write_last_index(8'd0);
    send_query(32'sh8000_0000);
    send_query(32'sd0);
  endtask

  // segments whose ends straddle pi: negative end first, positive end first
  task automatic test_angle_wrap();
    write_last_index(8'd4);
    send_query(-32'sd1000000000);
    send_query(-32'sd65537);
    send_query(32'sd65536);
  endtask

  // a later entry at the same position overrides an earlier exact hit
  task automatic test_repeated_match();
    send_load(8'd3, 32'sd0, 31'sd123456789);
    send_query(32'sd0);
    send_query(32'sd65536);
  endtask

  // phases of random tables under different scan bounds, including both
  // extremes, with stray loads mixed into the queries
  task automatic test_random_phases();
    int phase, top, n_queries;
    phase = 0;
    while (item_count < TOTAL_ITEMS) begin
      if (phase == 0) top = 255;
      else if (phase == 1) top = 0;
      // wide tables only while there is room left in the item budget
      else if ($urandom_range(3) == 0 && item_count + 320 < TOTAL_ITEMS)
        top = int'($urandom_range(254, 1));
      else top = int'($urandom_range(15, 1));
      // one phase with no idling on either side
      no_idle = (phase == 2);
      write_last_index(IDX_W'(top));
      load_random_table(top);
      n_queries = 30 + int'($urandom_range(30));
      repeat (n_queries) begin
        if ($urandom_range(99) < 8) send_load(IDX_W'($urandom()), POS_W'($urandom()), rand_heading());
        else send_query(pick_query(top));
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random back-pressure on the result channel
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each result item with the oldest predicted heading
  always @(posedge clk) begin
    heading_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser) found_count++;
      else outside_count++;
      if (heading_expect_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result at %0t: heading %0d found %0b",
                   $time, $signed(out_tdata[HEAD_W-1:0]), out_tuser);
        fail_count++;
      end else begin
        want = heading_expect_q.pop_front();
        if (out_tdata[HEAD_W-1:0] !== want.heading || out_tuser !== want.found) begin
          if (fail_count < 10)
            $display("mismatch at %0t: expected heading %0d found %0b, got heading %0d found %0b",
                     $time, $signed(want.heading), want.found,
                     $signed(out_tdata[HEAD_W-1:0]), out_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("heading_angle_interpolation verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // synchronous reset, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_table_extremes();
    test_angle_wrap();
    test_repeated_match();
    test_random_phases();

    // let every owed heading arrive, then watch for stray results
    drain_block();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d table loads and %0d queries over %0d scan bound settings",
             load_count, query_count, setting_count);
    $display("%0d queries landed in the table, %0d fell outside, %0d failures",
             found_count, outside_count, fail_count);
    if (fail_count == 0) begin
      $display("heading_angle_interpolation verification clean");
    end else begin
      $display("heading_angle_interpolation verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hai_pkg.sv
design/hai_ram.sv
design/hai_muldiv.sv
design/heading_angle_interpolation.sv
dv/heading_angle_interpolation_tb.sv
